// File: rtl/core/bdfs_pkg.sv
// ----------------------------------------------------------------------------
// bdfs_pkg
// Shared types and constants for the brace-depth frame splitter.
// ----------------------------------------------------------------------------
package bdfs_pkg;

  // size of the frame buffer on the receiving side
  localparam int BufferBytes = 128;
  localparam int KeepLimitInt = (BufferBytes - 1 > 127) ? 127 : (BufferBytes - 1);
  localparam logic [6:0] KeepLimit = 7'(KeepLimitInt);

  localparam logic [7:0] OpenBrace  = 8'h7B;
  localparam logic [7:0] CloseBrace = 8'h7D;

  localparam logic [7:0]  DepthMax   = 8'hFF;
  localparam logic [15:0] ElapsedMax = 16'hFFFF;

  localparam logic [15:0] PollIntervalReset = 16'd1000;
  localparam logic [15:0] GapAfterDataReset = 16'd25;

  // configuration register indexes
  localparam logic CfgPollInterval = 1'b0;
  localparam logic CfgGapAfterData = 1'b1;

  // item kinds
  localparam logic FuncByte = 1'b0;
  localparam logic FuncTick = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       rx_empty;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_kept;
    logic       frame_end;
    logic [6:0] frame_length;
    logic       truncated;
    logic       poll_request;
  } result_t;

endpackage

// File: rtl/core/bdfs_in_reg.sv
// ----------------------------------------------------------------------------
// bdfs_in_reg
// Input register: captures one item from the slave stream.
// ----------------------------------------------------------------------------
module bdfs_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,   // rx_byte[7:0], rx_empty[8], zero[15:9]
  input  logic            s_axis_tuser,   // func[0]
  output logic            item_valid_o,
  output bdfs_pkg::item_t item_o,
  input  logic            item_ready_i
);

  logic            valid_q, valid_d;
  bdfs_pkg::item_t item_q;
  logic            load;

  assign s_axis_tready = !valid_q || item_ready_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.func     <= s_axis_tuser;
      item_q.rx_byte  <= s_axis_tdata[7:0];
      item_q.rx_empty <= s_axis_tdata[8];
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: rtl/core/bdfs_engine.sv
// ----------------------------------------------------------------------------
// bdfs_engine
// Frame and poll state with the single-pass update for one item.
// ----------------------------------------------------------------------------
module bdfs_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              step_i,
  input  bdfs_pkg::item_t   item_i,
  output bdfs_pkg::result_t result_o
);

  logic [15:0] poll_interval_q;
  logic [15:0] gap_after_data_q;
  logic [7:0]  nest_depth_q, nest_depth_d;
  logic [6:0]  kept_count_q, kept_count_d;
  logic        dropped_flag_q, dropped_flag_d;
  logic [15:0] elapsed_ticks_q, elapsed_ticks_d;

  logic [15:0] gap;
  logic [15:0] elapsed_inc;
  logic [6:0]  kept_inc;
  logic        dropped_now;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    result_o        = '0;
    nest_depth_d    = nest_depth_q;
    kept_count_d    = kept_count_q;
    dropped_flag_d  = dropped_flag_q;
    elapsed_ticks_d = elapsed_ticks_q;
    gap = (gap_after_data_q > poll_interval_q) ? poll_interval_q : gap_after_data_q;
    elapsed_inc = (elapsed_ticks_q < bdfs_pkg::ElapsedMax) ? (elapsed_ticks_q + 16'd1)
                                                            : elapsed_ticks_q;
    kept_inc    = kept_count_q;
    dropped_now = dropped_flag_q;

    if (item_i.func == bdfs_pkg::FuncByte) begin
      result_o.out_byte = item_i.rx_byte;
      if (kept_count_q < bdfs_pkg::KeepLimit) begin
        kept_inc           = kept_count_q + 7'd1;
        result_o.byte_kept = 1'b1;
      end else begin
        dropped_now = 1'b1;
      end
      kept_count_d   = kept_inc;
      dropped_flag_d = dropped_now;

      if (item_i.rx_byte == bdfs_pkg::OpenBrace) begin
        if (nest_depth_q != bdfs_pkg::DepthMax) begin
          nest_depth_d = nest_depth_q + 8'd1;
        end
      end else if (item_i.rx_byte == bdfs_pkg::CloseBrace) begin
        if (nest_depth_q <= 8'd1) begin
          // outermost close: report and start a new frame
          nest_depth_d          = '0;
          result_o.frame_end    = 1'b1;
          result_o.frame_length = kept_inc;
          result_o.truncated    = dropped_now;
          kept_count_d          = '0;
          dropped_flag_d        = 1'b0;
        end else begin
          nest_depth_d = nest_depth_q - 8'd1;
        end
      end
      elapsed_ticks_d = poll_interval_q - gap;
    end else begin
      elapsed_ticks_d = elapsed_inc;
      if (item_i.rx_empty && (elapsed_inc > poll_interval_q)) begin
        result_o.poll_request = 1'b1;
        elapsed_ticks_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_interval_q  <= bdfs_pkg::PollIntervalReset;
      gap_after_data_q <= bdfs_pkg::GapAfterDataReset;
      nest_depth_q     <= '0;
      kept_count_q     <= '0;
      dropped_flag_q   <= 1'b0;
      elapsed_ticks_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bdfs_pkg::CfgPollInterval: poll_interval_q  <= cfg_data_i;
          bdfs_pkg::CfgGapAfterData: gap_after_data_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (step_i) begin
        nest_depth_q    <= nest_depth_d;
        kept_count_q    <= kept_count_d;
        dropped_flag_q  <= dropped_flag_d;
        elapsed_ticks_q <= elapsed_ticks_d;
      end
    end
  end

endmodule

// File: rtl/core/bdfs_out_reg.sv
// ----------------------------------------------------------------------------
// bdfs_out_reg
// Result register driving the master stream.
// ----------------------------------------------------------------------------
module bdfs_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              result_valid_i,
  output logic              result_ready_o,
  input  bdfs_pkg::result_t result_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // out_byte[7:0], byte_kept[8], frame_length[15:9], truncated[16], zero[23:17]
  output logic [23:0]       m_axis_tdata,
  output logic              m_axis_tlast,   // frame_end[0]
  output logic              m_axis_tuser    // poll_request[0]
);

  logic              valid_q, valid_d;
  bdfs_pkg::result_t result_q;
  logic              load;

  assign result_ready_o = !valid_q || m_axis_tready;
  assign load           = result_valid_i && result_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {7'd0, result_q.truncated, result_q.frame_length,
                          result_q.byte_kept, result_q.out_byte};
  assign m_axis_tlast  = result_q.frame_end;
  assign m_axis_tuser  = result_q.poll_request;

endmodule

// File: rtl/core/brace_depth_frame_splitter_core.sv
// ----------------------------------------------------------------------------
// brace_depth_frame_splitter_core
// Splits a received byte stream into brace-delimited frames and paces
// keep-alive polls.
// ----------------------------------------------------------------------------
// usage:
//   the slave stream carries one item per transaction: tuser selects a
//   received byte (0) or a time tick (1), tdata holds the byte and, for
//   ticks, the receiver-empty flag. the master stream returns exactly one
//   result per item: the byte with its kept flag, frame length and
//   truncation in tdata, tlast marking the byte that closes a frame, tuser
//   marking a keep-alive poll request.
//   the cfg channel writes poll_interval (index 0) and gap_after_data
//   (index 1); it is always ready. the user writes it only while no item is in
//   flight; the block itself does not enforce this.
//   throughput is one item per cycle while m_axis_tready stays high. an
//   accepted item passes through the input register, the single-pass
//   state update, then the result register.
//   reset clears depth, frame counters and the tick timer and restores the
//   register defaults (1000 and 25); no clearing pass is needed.
//   when the receiver stalls the result register holds, the input register
//   fills, and only then does s_axis_tready drop.
// ----------------------------------------------------------------------------
module brace_depth_frame_splitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], rx_empty[8], zero[15:9]
  input  logic        s_axis_tuser,   // func[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], byte_kept[8], frame_length[15:9], truncated[16], zero[23:17]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,   // frame_end[0]
  output logic        m_axis_tuser,   // poll_request[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic              item_valid;
  logic              item_ready;
  bdfs_pkg::item_t   item;
  bdfs_pkg::result_t result;
  logic              step;

  bdfs_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_ready_i  (item_ready)
  );

  assign step = item_valid && item_ready;

  bdfs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .item_i      (item),
    .result_o    (result)
  );

  bdfs_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .result_valid_i (item_valid),
    .result_ready_o (item_ready),
    .result_i       (result),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .m_axis_tuser   (m_axis_tuser)
  );

endmodule

// File: dv/bdfs_frame_checker.sv
// ----------------------------------------------------------------------------
// bdfs_frame_checker
// Watches the item, result and register channels of the frame splitter,
// works out the result of every accepted item and compares it field by field
// with the results that come out, in order.
// ----------------------------------------------------------------------------
module bdfs_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        m_tuser_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] interval_q;
  logic [15:0] gap_q;
  logic [7:0]  depth_q;
  logic [6:0]  kept_q;
  logic        dropped_q;
  logic [15:0] elapsed_q;

  bdfs_pkg::result_t frame_results_q[$];
  bdfs_pkg::result_t got;
  bdfs_pkg::result_t want;
  bdfs_pkg::item_t   item;
  int                result_idx;

  function automatic bdfs_pkg::result_t next_frame_result(bdfs_pkg::item_t it);
    bdfs_pkg::result_t r;
    logic [15:0]       gap;
    r = '0;
    if (it.func == bdfs_pkg::FuncByte) begin
      r.out_byte = it.rx_byte;
      if (kept_q < bdfs_pkg::KeepLimit) begin
        kept_q      = kept_q + 7'd1;
        r.byte_kept = 1'b1;
      end else begin
        dropped_q = 1'b1;
      end
      if (it.rx_byte == bdfs_pkg::OpenBrace) begin
        if (depth_q != bdfs_pkg::DepthMax) depth_q = depth_q + 8'd1;
      end else if (it.rx_byte == bdfs_pkg::CloseBrace) begin
        // a closing brace at depth 0 or 1 ends the frame
        if (depth_q <= 8'd1) begin
          depth_q        = '0;
          r.frame_end    = 1'b1;
          r.frame_length = kept_q;
          r.truncated    = dropped_q;
          kept_q         = '0;
          dropped_q      = 1'b0;
        end else begin
          depth_q = depth_q - 8'd1;
        end
      end
      gap       = (gap_q > interval_q) ? interval_q : gap_q;
      elapsed_q = interval_q - gap;
    end else begin
      if (elapsed_q != bdfs_pkg::ElapsedMax) elapsed_q = elapsed_q + 16'd1;
      if (it.rx_empty && elapsed_q > interval_q) begin
        r.poll_request = 1'b1;
        elapsed_q      = '0;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q = bdfs_pkg::PollIntervalReset;
      gap_q      = bdfs_pkg::GapAfterDataReset;
      depth_q    = '0;
      kept_q     = '0;
      dropped_q  = 1'b0;
      elapsed_q  = '0;
      frame_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      result_idx   = 0;
    end else begin
      // results first: an item accepted at this edge cannot be out yet
      if (m_tvalid_i && m_tready_i) begin
        got.out_byte     = m_tdata_i[7:0];
        got.byte_kept    = m_tdata_i[8];
        got.frame_length = m_tdata_i[15:9];
        got.truncated    = m_tdata_i[16];
        got.frame_end    = m_tlast_i;
        got.poll_request = m_tuser_i;
        if (frame_results_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result %0d: byte %h kept %b end %b len %0d trunc %b poll %b",
                     result_idx, got.out_byte, got.byte_kept, got.frame_end,
                     got.frame_length, got.truncated, got.poll_request);
        end else begin
          want = frame_results_q.pop_front();
          if (got.out_byte !== want.out_byte || got.byte_kept !== want.byte_kept ||
              got.frame_end !== want.frame_end || got.frame_length !== want.frame_length ||
              got.truncated !== want.truncated || got.poll_request !== want.poll_request)
          begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("result %0d mismatch", result_idx);
              $display("  expected byte %h kept %b end %b len %0d trunc %b poll %b",
                       want.out_byte, want.byte_kept, want.frame_end,
                       want.frame_length, want.truncated, want.poll_request);
              $display("  actual   byte %h kept %b end %b len %0d trunc %b poll %b",
                       got.out_byte, got.byte_kept, got.frame_end,
                       got.frame_length, got.truncated, got.poll_request);
            end
          end
        end
        result_idx++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == bdfs_pkg::CfgPollInterval) interval_q = cfg_data_i;
        else gap_q = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        item.func     = s_tuser_i;
        item.rx_byte  = s_tdata_i[7:0];
        item.rx_empty = s_tdata_i[8];
        frame_results_q.push_back(next_frame_result(item));
      end
      pending_o = frame_results_q.size();
    end
  end

endmodule

// File: dv/tb_brace_depth_frame_splitter_core.sv
// ----------------------------------------------------------------------------
// tb_brace_depth_frame_splitter_core
// Drives directed and random byte/tick streams through the frame splitter
// over several poll settings, with random stalls on both streams and one
// long receiver hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_brace_depth_frame_splitter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPhases      = 8;
  localparam int PhaseItems     = 140;
  localparam int LongHoldCycles = 300;
  localparam int DeepNest       = 260;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = bdfs_pkg::CfgPollInterval;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pending;

  bit idle_on = 1'b1;
  bit hold_off_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  brace_depth_frame_splitter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  bdfs_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // rx_empty is ignored on bytes, so it carries random noise
  function automatic bdfs_pkg::item_t byte_item(logic [7:0] b);
    bdfs_pkg::item_t it;
    it.func     = bdfs_pkg::FuncByte;
    it.rx_byte  = b;
    it.rx_empty = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic bdfs_pkg::item_t tick_item(logic empty);
    bdfs_pkg::item_t it;
    it.func     = bdfs_pkg::FuncTick;
    it.rx_byte  = 8'($urandom_range(0, 255));
    it.rx_empty = empty;
    return it;
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == bdfs_pkg::OpenBrace || b == bdfs_pkg::CloseBrace) b = 8'h20;
    return b;
  endfunction

  task automatic offer_item(bdfs_pkg::item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.func;
    s_tdata  <= {7'd0, it.rx_empty, it.rx_byte};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic offer_all(ref bdfs_pkg::item_t items[$]);
    foreach (items[k]) offer_item(items[k]);
  endtask

  // let the checker see the last accepted transaction before reading the count
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [15:0] interval, logic [15:0] gap);
    cfg_valid <= 1'b1;
    cfg_index <= bdfs_pkg::CfgPollInterval;
    cfg_data  <= interval;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= bdfs_pkg::CfgGapAfterData;
    cfg_data  <= gap;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // receiver side: random stall per result, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        stall        = LongHoldCycles;
        hold_off_req = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, 19) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    bdfs_pkg::item_t items[$];
    logic [15:0]     interval;
    logic [15:0]     gap;
    int              sel;
    int              depth;
    int              body;
    int              run;
    int              sent;
    bit              deep_done;

    deep_done = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: stray close, byte extremes, nested frame
    items.push_back(byte_item(bdfs_pkg::CloseBrace));
    items.push_back(byte_item(8'h00));
    items.push_back(byte_item(8'hFF));
    items.push_back(byte_item(bdfs_pkg::OpenBrace));
    items.push_back(byte_item(8'h61));
    items.push_back(byte_item(bdfs_pkg::OpenBrace));
    items.push_back(byte_item(bdfs_pkg::CloseBrace));
    items.push_back(byte_item(bdfs_pkg::CloseBrace));
    items.push_back(tick_item(1'b1));
    offer_all(items);
    wait_idle();

    // gap above the interval clamps to it, then count up to a poll
    write_regs(16'd3, 16'hFFFF);
    items.delete();
    items.push_back(byte_item(8'h78));
    items.push_back(tick_item(1'b1));
    items.push_back(tick_item(1'b1));
    items.push_back(tick_item(1'b0));
    items.push_back(tick_item(1'b0));
    items.push_back(tick_item(1'b1));
    items.push_back(tick_item(1'b1));
    offer_all(items);

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      unique case (p)
        0: begin
          interval = bdfs_pkg::PollIntervalReset;
          gap      = bdfs_pkg::GapAfterDataReset;
        end
        1: begin interval = 16'd1;     gap = 16'd0;     end
        2: begin interval = 16'hFFFF;  gap = 16'd0;     end
        3: begin interval = 16'hFFFF;  gap = 16'hFFFF;  end
        4: begin interval = 16'd20;    gap = 16'd3;     end
        5: begin interval = 16'd1;     gap = 16'hFFFF;  end
        default: begin
          interval = 16'($urandom_range(1, 60));
          gap      = 16'($urandom_range(0, 80));
        end
      endcase
      write_regs(interval, gap);
      if (p == 1) hold_off_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        idle_on = ($urandom_range(0, 3) != 0);
        items.delete();
        sel = $urandom_range(0, 9);
        if (p == 4 && !deep_done) begin
          // depth saturates, then the surplus closes end frames that hold only the brace
          deep_done = 1'b1;
          repeat (DeepNest) items.push_back(byte_item(bdfs_pkg::OpenBrace));
          items.push_back(byte_item(8'h78));
          repeat (DeepNest) items.push_back(byte_item(bdfs_pkg::CloseBrace));
        end else if (sel <= 5) begin
          items.push_back(byte_item(bdfs_pkg::OpenBrace));
          depth = 1;
          body = ($urandom_range(0, 7) == 0) ? $urandom_range(120, 200)
                                             : $urandom_range(0, 30);
          for (int k = 0; k < body; k++) begin
            run = $urandom_range(0, 9);
            if (run == 0 && depth < 6) begin
              items.push_back(byte_item(bdfs_pkg::OpenBrace));
              depth++;
            end else if (run == 1 && depth > 1) begin
              items.push_back(byte_item(bdfs_pkg::CloseBrace));
              depth--;
            end else if (run == 2) begin
              items.push_back(tick_item(1'b0));
            end else begin
              items.push_back(byte_item(filler_byte()));
            end
          end
          while (depth > 0) begin
            items.push_back(byte_item(bdfs_pkg::CloseBrace));
            depth--;
          end
        end else if (sel <= 7) begin
          run = $urandom_range(1, 60);
          repeat (run) items.push_back(tick_item(1'($urandom_range(0, 7) != 0)));
        end else begin
          run = $urandom_range(1, 20);
          repeat (run) items.push_back(byte_item(8'($urandom_range(0, 255))));
        end
        offer_all(items);
        sent += items.size();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bdfs_pkg.sv
rtl/core/bdfs_in_reg.sv
rtl/core/bdfs_engine.sv
rtl/core/bdfs_out_reg.sv
rtl/core/brace_depth_frame_splitter_core.sv
dv/bdfs_frame_checker.sv
dv/tb_brace_depth_frame_splitter_core.sv
